// File: hw/rtl/sdd_pkg.sv
// ----------------------------------------------------------------------------
// sdd_pkg: shared types and constants for the stitch delta stream decoder
// Holds the result record and the byte codes of the stitch record format.
// ----------------------------------------------------------------------------
package sdd_pkg;

    // Escape marker in the x position of a short record
    localparam logic [7:0] ESC_BYTE = 8'h80;
    // Selector that opens a long (trim) record
    localparam logic [7:0] SEL_LONG = 8'h01;

    // Stitch kinds
    localparam logic KIND_NORMAL = 1'b0;
    localparam logic KIND_TRIM   = 1'b1;

    // One decoded stitch
    typedef struct packed {
        logic               truncated;
        logic               stitch_kind;
        logic signed [15:0] delta_y;
        logic signed [15:0] delta_x;
    } t_result;

endpackage

// File: hw/rtl/sdd_parser.sv
// ----------------------------------------------------------------------------
// sdd_parser: input register and record parser
// Registers each incoming beat, advances the record phase and forms at most
// one stitch result per byte in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module sdd_parser
    import sdd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Byte side
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_end,
    // Result side
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_result    o_res
);

    // Record phases
    localparam logic [2:0] PH_X     = 3'd0;
    localparam logic [2:0] PH_SEL   = 3'd1;
    localparam logic [2:0] PH_XH    = 3'd2;
    localparam logic [2:0] PH_XL    = 3'd3;
    localparam logic [2:0] PH_YH    = 3'd4;
    localparam logic [2:0] PH_YL    = 3'd5;
    localparam logic [2:0] PH_SKIP1 = 3'd6;
    localparam logic [2:0] PH_SKIP2 = 3'd7;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;

    logic [2:0]  r_phase,  n_phase;
    logic [7:0]  r_x_byte, n_x_byte;
    logic [7:0]  r_high,   n_high;
    logic [15:0] r_long_x, n_long_x;

    logic        w_done;
    logic        w_emit;
    t_result     w_res;
    logic        w_fire;

    // Sign-extend a short delta; the escape value itself reads as +128
    function automatic logic [15:0] short_delta(input logic [7:0] b);
        if (b > ESC_BYTE) begin
            short_delta = {8'hFF, b};
        end else begin
            short_delta = {8'h00, b};
        end
    endfunction

    // Consume the held byte when no result is formed or the result is taken
    assign w_fire      = r_in_valid && (!w_emit || i_res_ready);
    assign o_in_ready  = !r_in_valid || w_fire;
    assign o_res_valid = r_in_valid && w_emit;
    assign o_res       = w_res;

    // Hold the incoming beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_in_end;
        end
    end

    // Decode one byte against the current phase
    always_comb begin
        n_phase  = r_phase;
        n_x_byte = r_x_byte;
        n_high   = r_high;
        n_long_x = r_long_x;
        w_done   = 1'b0;
        w_emit   = 1'b0;
        w_res    = '0;
        unique case (r_phase)
            PH_X: begin
                n_x_byte = r_in_byte;
                n_phase  = PH_SEL;
            end
            PH_SEL: begin
                w_done  = 1'b1;
                n_phase = PH_X;
                if (r_x_byte == ESC_BYTE) begin
                    if (r_in_byte == SEL_LONG) begin
                        w_done  = 1'b0;
                        n_phase = PH_XH;
                    end
                end else begin
                    w_emit            = 1'b1;
                    w_res.delta_x     = short_delta(r_x_byte);
                    w_res.delta_y     = short_delta(r_in_byte);
                    w_res.stitch_kind = KIND_NORMAL;
                end
            end
            PH_XH: begin
                n_high  = r_in_byte;
                n_phase = PH_XL;
            end
            PH_XL: begin
                n_long_x = {r_high, r_in_byte};
                n_phase  = PH_YH;
            end
            PH_YH: begin
                n_high  = r_in_byte;
                n_phase = PH_YL;
            end
            PH_YL: begin
                w_emit            = 1'b1;
                w_res.delta_x     = r_long_x;
                w_res.delta_y     = {r_high, r_in_byte};
                w_res.stitch_kind = KIND_TRIM;
                n_phase           = PH_SKIP1;
            end
            PH_SKIP1: begin
                n_phase = PH_SKIP2;
            end
            PH_SKIP2: begin
                w_done  = 1'b1;
                n_phase = PH_X;
            end
            default: begin
                n_phase = PH_X;
            end
        endcase

        // Block end: flag an unfinished record and drop back to reset state
        if (r_in_end) begin
            if (!w_done) begin
                w_emit          = 1'b1;
                w_res           = '0;
                w_res.truncated = 1'b1;
            end
            n_phase  = PH_X;
            n_x_byte = '0;
            n_high   = '0;
            n_long_x = '0;
        end
    end

    // Advance the parse state on each consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_X;
            r_x_byte <= '0;
            r_high   <= '0;
            r_long_x <= '0;
        end else if (w_fire) begin
            r_phase  <= n_phase;
            r_x_byte <= n_x_byte;
            r_high   <= n_high;
            r_long_x <= n_long_x;
        end
    end

`ifndef ASSERT_OFF
    // A block end always leaves the parser at the start of a record
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_end) |=> (r_phase == PH_X && r_long_x == '0))
        else $error("parser not reset after block end");

    // A truncated result carries zero deltas and a normal kind
    a_trunc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.truncated) |->
        (o_res.delta_x == '0 && o_res.delta_y == '0 && o_res.stitch_kind == KIND_NORMAL))
        else $error("truncated result with nonzero payload");

    // A trim only comes from the low byte of the long y delta
    a_trim_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.stitch_kind == KIND_TRIM) |->
        (r_phase == PH_YL && !r_in_end))
        else $error("trim result outside long y low byte");
`endif

endmodule

// File: hw/rtl/sdd_out_buf.sv
// ----------------------------------------------------------------------------
// sdd_out_buf: two-entry result buffer
// Registers results so the parser keeps taking bytes while the sink stalls.
// ----------------------------------------------------------------------------
module sdd_out_buf
    import sdd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    output logic    o_push_ready,
    input  t_result i_push_data,
    output logic    o_pop_valid,
    input  logic    i_pop_ready,
    output t_result o_pop_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Store results
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hw/rtl/stitch_delta_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// stitch_delta_stream_decoder_top: stitch record decoder
// Decodes short and long stitch records from a byte stream.
//
//   channel  dir  tdata                          tuser / tlast
//   s_axis   in   [7:0] in_byte                  tlast = block_end
//   m_axis   out  [15:0] delta_x, [31:16] delta_y tuser[0] kind, [1] truncated
//
// One byte is taken every cycle while the result buffer has room; a result
// leaves via the input register, then the result buffer. The per-byte phase
// update in the parser sets the rate. Reset (synchronous, active low) returns
// the parser to the first x byte and empties both stages. A stalled sink fills
// the two-entry result buffer before the byte side is held.
// ----------------------------------------------------------------------------
module stitch_delta_stream_decoder_top
    import sdd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // block_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] delta_x, [31:16] delta_y
    output logic [1:0]  m_axis_tuser    // [0] stitch_kind, [1] truncated
);

    logic    w_res_valid;
    logic    w_res_ready;
    t_result w_res;
    t_result w_out;

    // Parse bytes into stitch results
    sdd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .i_in_end    (s_axis_tlast),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // Buffer results toward the sink
    sdd_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_res_valid),
        .o_push_ready (w_res_ready),
        .i_push_data  (w_res),
        .o_pop_valid  (m_axis_tvalid),
        .i_pop_ready  (m_axis_tready),
        .o_pop_data   (w_out)
    );

    // Pack the result beat
    assign m_axis_tdata = {w_out.delta_y, w_out.delta_x};
    assign m_axis_tuser = {w_out.truncated, w_out.stitch_kind};

endmodule
